>>> src/smot_pkg.sv
package smot_pkg;

    // Geometry of the tracked scratch memory and the widest access.
    localparam int MEM_BYTES        = 16384;
    localparam int MAX_ACCESS_BYTES = 16;

    localparam int ADDR_W  = $clog2(MEM_BYTES);
    localparam int OFS_W   = $clog2(MAX_ACCESS_BYTES + 1);
    localparam int OWNER_W = 11;
    localparam int TID_W   = 10;
    localparam int CNT_W   = 32;
    localparam int RADDR_W = 14;
    localparam int SIZE_W  = 5;
    localparam int TCNT_W  = 11;
    localparam int MSIZE_W = 15;
    localparam int MASK_W  = 32;
    localparam int CIDX_W  = 2;
    localparam int CDATA_W = 32;

    localparam logic [OWNER_W-1:0] OWNER_NONE = '1;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_THREAD_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_MEM_SIZE     = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_ADDRESS_MASK = 2'd2;

    // Access kinds.
    localparam logic ACT_STORE = 1'b0;
    localparam logic ACT_LOAD  = 1'b1;

    typedef enum logic [5:0] {
        S_CLEAR   = 6'b000001,
        S_IDLE    = 6'b000010,
        S_STORE   = 6'b000100,
        S_LOAD_RD = 6'b001000,
        S_LOAD_CK = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

endpackage

>>> src/shared_memory_owner_tracker_core.sv
// Shared-memory owner tracker.
// Each input transfer is one thread's shared-memory access (action, thread_id,
// address, size, masked_store); each one yields exactly one output transfer
// with the load report and the four running counters after that access.
// The cfg channel writes thread_count, mem_size and address_mask by index;
// write it only while no access is in flight. cfg_ready is always high.
// An ignored access or a zero-size store goes straight to the finish state; a load
// reads the owner table and then checks the owner; a store of n bytes
// (size clamped to MAX_ACCESS_BYTES) writes its bytes one after another, since
// the single write port of the owner table takes one byte per cycle.
// A new access is taken only once the last one's result has gone to the output register.
// After reset the owner table is swept to "none", one entry per cycle, over all
// MEM_BYTES (16384) entries; in_ready stays low during that sweep.
// The result sits in an output register: while the receiver stalls, the block
// takes and works on the next access, and holds that one's result until the
// output register frees up.
module shared_memory_owner_tracker_core (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [smot_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [smot_pkg::CDATA_W-1:0]  cfg_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          action,
    input  logic [smot_pkg::TID_W-1:0]    thread_id,
    input  logic [31:0]                   address,
    input  logic [smot_pkg::SIZE_W-1:0]   size,
    input  logic                          masked_store,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          cross_thread_read,
    output logic                          ignored,
    output logic [smot_pkg::TID_W-1:0]    reader_thread,
    output logic [smot_pkg::TID_W-1:0]    source_thread,
    output logic [smot_pkg::RADDR_W-1:0]  read_address,
    output logic [smot_pkg::SIZE_W-1:0]   read_size,
    output logic [smot_pkg::CNT_W-1:0]    store_count,
    output logic [smot_pkg::CNT_W-1:0]    load_count,
    output logic [smot_pkg::CNT_W-1:0]    store_oob_count,
    output logic [smot_pkg::CNT_W-1:0]    load_oob_count
);

    import smot_pkg::*;

    // Control state
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_addr_reg, clr_addr_next;
    logic [OFS_W-1:0]     ofs_reg, ofs_next;
    logic                 out_valid_reg, out_valid_next;

    // Configuration
    logic [TCNT_W-1:0]    thread_count_reg;
    logic [MSIZE_W-1:0]   mem_size_reg;
    logic [MASK_W-1:0]    address_mask_reg;

    // Counters
    logic [CNT_W-1:0]     stores_reg, stores_next;
    logic [CNT_W-1:0]     loads_reg, loads_next;
    logic [CNT_W-1:0]     store_oob_reg, store_oob_next;
    logic [CNT_W-1:0]     load_oob_reg, load_oob_next;

    // Captured access and pending result
    logic                 act_reg;
    logic [TID_W-1:0]     tid_reg;
    logic [31:0]          base_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic [OFS_W-1:0]     len_reg;
    logic [OWNER_W-1:0]   who_reg;
    logic                 ign_reg;
    logic                 load_inb_reg;
    logic                 cross_reg;
    logic [TID_W-1:0]     source_reg;

    // Output payload
    logic                 o_cross_reg;
    logic                 o_ign_reg;
    logic [TID_W-1:0]     o_reader_reg;
    logic [TID_W-1:0]     o_source_reg;
    logic [RADDR_W-1:0]   o_raddr_reg;
    logic [SIZE_W-1:0]    o_rsize_reg;
    logic [CNT_W-1:0]     o_stores_reg;
    logic [CNT_W-1:0]     o_loads_reg;
    logic [CNT_W-1:0]     o_store_oob_reg;
    logic [CNT_W-1:0]     o_load_oob_reg;

    // Datapath
    logic                 in_xfer;
    logic                 out_xfer;
    logic                 out_load;
    logic                 in_ignored;
    logic [OFS_W-1:0]     in_len;
    logic [31:0]          store_addr;
    logic                 store_inb;
    logic [31:0]          load_addr;
    logic                 load_inb;

    logic                 ram_wr_en;
    logic [ADDR_W-1:0]    ram_wr_addr;
    logic [OWNER_W-1:0]   ram_wr_data;
    logic                 ram_rd_en;
    logic [OWNER_W-1:0]   ram_rd_data;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign out_xfer  = out_valid_reg && out_ready;
    // Move the pending result into the output register once it is free.
    assign out_load  = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    assign in_ignored = ({1'b0, thread_id} >= thread_count_reg);
    assign in_len = (32'(size) > 32'(MAX_ACCESS_BYTES)) ? OFS_W'(MAX_ACCESS_BYTES)
                                                        : OFS_W'(size);

    // Byte address of the current store offset, wrapped before masking.
    assign store_addr = (base_reg + 32'(ofs_reg)) & address_mask_reg;
    assign store_inb  = (store_addr < {17'b0, mem_size_reg}) &&
                        (store_addr < 32'(MEM_BYTES));
    assign load_addr  = base_reg & address_mask_reg;
    assign load_inb   = (load_addr < {17'b0, mem_size_reg}) &&
                        (load_addr < 32'(MEM_BYTES));

    always_comb
    begin
        ram_wr_en   = 1'b0;
        ram_wr_addr = store_addr[ADDR_W-1:0];
        ram_wr_data = who_reg;
        case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = OWNER_NONE;
            end
            S_STORE:
            begin
                ram_wr_en = store_inb;
            end
            default:
            begin
                ram_wr_en = 1'b0;
            end
        endcase
    end

    assign ram_rd_en = (state_reg == S_LOAD_RD);

    smot_ram #(
        .WIDTH (OWNER_W),
        .DEPTH (MEM_BYTES)
    ) u_owner_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (load_addr[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        clr_addr_next  = clr_addr_reg;
        ofs_next       = ofs_reg;
        stores_next    = stores_reg;
        loads_next     = loads_reg;
        store_oob_next = store_oob_reg;
        load_oob_next  = load_oob_reg;
        out_valid_next = out_valid_reg;

        if (out_xfer)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                ofs_next = '0;
                if (in_xfer)
                begin
                    if (in_ignored)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (action == ACT_STORE)
                    begin
                        stores_next = stores_reg + 1'b1;
                        state_next  = (in_len == '0) ? S_FINISH : S_STORE;
                    end
                    else
                    begin
                        loads_next = loads_reg + 1'b1;
                        state_next = S_LOAD_RD;
                    end
                end
            end
            S_STORE:
            begin
                // Write one owner byte per cycle; drop out-of-bounds bytes.
                if (!store_inb)
                begin
                    store_oob_next = store_oob_reg + 1'b1;
                end
                ofs_next = ofs_reg + 1'b1;
                if (ofs_reg + 1'b1 == len_reg)
                begin
                    state_next = S_FINISH;
                end
            end
            S_LOAD_RD:
            begin
                if (!load_inb)
                begin
                    load_oob_next = load_oob_reg + 1'b1;
                end
                state_next = S_LOAD_CK;
            end
            S_LOAD_CK:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            ofs_reg          <= '0;
            out_valid_reg    <= 1'b0;
            stores_reg       <= '0;
            loads_reg        <= '0;
            store_oob_reg    <= '0;
            load_oob_reg     <= '0;
            thread_count_reg <= TCNT_W'(1024);
            mem_size_reg     <= MSIZE_W'(16384);
            address_mask_reg <= MASK_W'(16383);
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            ofs_reg       <= ofs_next;
            out_valid_reg <= out_valid_next;
            stores_reg    <= stores_next;
            loads_reg     <= loads_next;
            store_oob_reg <= store_oob_next;
            load_oob_reg  <= load_oob_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_THREAD_COUNT: thread_count_reg <= cfg_data[TCNT_W-1:0];
                    CFG_MEM_SIZE:     mem_size_reg     <= cfg_data[MSIZE_W-1:0];
                    CFG_ADDRESS_MASK: address_mask_reg <= cfg_data[MASK_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    // Payload registers: capture on input transfer, build result, then hand off.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            act_reg    <= action;
            tid_reg    <= thread_id;
            base_reg   <= address;
            size_reg   <= size;
            len_reg    <= in_len;
            who_reg    <= masked_store ? OWNER_NONE : {1'b0, thread_id};
            ign_reg    <= in_ignored;
            cross_reg  <= 1'b0;
            source_reg <= '0;
        end
        if (state_reg == S_LOAD_RD)
        begin
            load_inb_reg <= load_inb;
        end
        if (state_reg == S_LOAD_CK)
        begin
            // Flag a load whose base byte belongs to some other thread.
            if (load_inb_reg && (ram_rd_data != OWNER_NONE) &&
                (ram_rd_data != {1'b0, tid_reg}))
            begin
                cross_reg  <= 1'b1;
                source_reg <= ram_rd_data[TID_W-1:0];
            end
        end
        if (out_load)
        begin
            o_cross_reg     <= cross_reg;
            o_ign_reg       <= ign_reg;
            o_stores_reg    <= stores_reg;
            o_loads_reg     <= loads_reg;
            o_store_oob_reg <= store_oob_reg;
            o_load_oob_reg  <= load_oob_reg;
            o_source_reg    <= source_reg;
            if (!ign_reg && (act_reg == ACT_LOAD))
            begin
                o_reader_reg <= tid_reg;
                o_raddr_reg  <= load_addr[RADDR_W-1:0];
                o_rsize_reg  <= size_reg;
            end
            else
            begin
                o_reader_reg <= '0;
                o_raddr_reg  <= '0;
                o_rsize_reg  <= '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign cross_thread_read = o_cross_reg;
    assign ignored           = o_ign_reg;
    assign reader_thread     = o_reader_reg;
    assign source_thread     = o_source_reg;
    assign read_address      = o_raddr_reg;
    assign read_size         = o_rsize_reg;
    assign store_count       = o_stores_reg;
    assign load_count        = o_loads_reg;
    assign store_oob_count   = o_store_oob_reg;
    assign load_oob_count    = o_load_oob_reg;

    // The owner table is written only by the reset sweep or a store walk.
    a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == S_CLEAR || state_reg == S_STORE))
        else $error("owner table written outside sweep or store");

    // A store walk never runs past its byte count.
    a_store_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STORE) |-> (ofs_reg < len_reg))
        else $error("store offset past access length");

    // A tracked load issues its owner read in the next cycle.
    a_load_read: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !in_ignored && action == ACT_LOAD) |=> (state_reg == S_LOAD_RD))
        else $error("load did not issue owner read");

    // A finished result never overwrites one that is still waiting.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !out_load)
        else $error("result register overrun");

endmodule

>>> src/smot_ram.sv
module smot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
